FILE: rtl/core/sequenced_event_ring_log_core_assert.svh
// Assertion macros shared by the sequenced event ring log modules.
`ifndef SEQUENCED_EVENT_RING_LOG_CORE_ASSERT_SVH
`define SEQUENCED_EVENT_RING_LOG_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define SERL_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SERL_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SERL_ASSERT_IMPL(name, ante, cons, msg)
`define SERL_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

FILE: rtl/core/serl_pkg.sv
// Shared types and constants of the sequenced event ring log.
package serl_pkg;

	// Fixed field widths.
	localparam int ID_W   = 16;
	localparam int AUX_W  = 32;
	localparam int SEEN_W = 16;

	// Defaults for the top-level parameters.
	localparam int DEF_LOG_DEPTH     = 16;
	localparam int DEF_COUNTER_LIMIT = 4096;

	// Request codes; only bit 0 of the request type is used.
	typedef enum logic {
		REQ_PUSH  = 1'b0,
		REQ_FETCH = 1'b1
	} serl_req_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_RANGE    = 2'd1,
		STATUS_EMPTY    = 2'd2,
		STATUS_NOTFOUND = 2'd3
	} serl_status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		SERL_IDLE,
		SERL_SCAN,
		SERL_FLUSH,
		SERL_EMIT
	} serl_state_t;

	// Control from the sequencer to the stamp-match unit.
	typedef struct packed {
		logic clear;   // Drop the hits of the previous transaction.
		logic cmp_en;  // Read data of a scanned slot is present.
		logic live;    // That slot has been written since reset.
	} serl_scan_ctl_t;

endpackage

FILE: rtl/core/serl_mem.sv
// Slot storage: one write port, one read port with registered read data.
module serl_mem #(
	parameter int DEPTH = serl_pkg::DEF_LOG_DEPTH,
	parameter int WIDTH = 92
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	import serl_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/serl_scan.sv
// Stamp-match unit: compares scanned slots against two wanted stamps.
`include "sequenced_event_ring_log_core_assert.svh"

module serl_scan #(
	parameter int COUNTER_LIMIT = serl_pkg::DEF_COUNTER_LIMIT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  serl_pkg::serl_scan_ctl_t ctl,
	input  logic [serl_pkg::ID_W+2*serl_pkg::AUX_W+$clog2(COUNTER_LIMIT)-1:0] rd_word,
	input  logic [$clog2(COUNTER_LIMIT)-1:0] tgt_first,
	input  logic [$clog2(COUNTER_LIMIT)-1:0] tgt_second,
	input  logic                   use_second,
	output logic                   found,
	output logic [serl_pkg::ID_W+2*serl_pkg::AUX_W+$clog2(COUNTER_LIMIT)-1:0] hit_word
);
	import serl_pkg::*;

	localparam int CW     = $clog2(COUNTER_LIMIT);
	localparam int WORD_W = ID_W + 2 * AUX_W + CW;
	localparam logic [ID_W-1:0] RESET_ID = ID_W'(COUNTER_LIMIT + 1);
	localparam logic [WORD_W-1:0] RESET_WORD = {RESET_ID, {(2 * AUX_W + CW){1'b0}}};

	logic [WORD_W-1:0] eff_word;
	logic [CW-1:0]     eff_stamp;
	logic              match_first;
	logic              match_second;
	logic              hit_first_q;
	logic              hit_second_q;
	logic [WORD_W-1:0] word_first_q;
	logic [WORD_W-1:0] word_second_q;

	// A slot not yet written since reset reads as its reset contents.
	assign eff_word     = ctl.live ? rd_word : RESET_WORD;
	assign eff_stamp    = eff_word[CW-1:0];
	assign match_first  = ctl.cmp_en && !hit_first_q && (eff_stamp == tgt_first);
	assign match_second = ctl.cmp_en && use_second && !hit_second_q &&
		(eff_stamp == tgt_second);

	// Hit flags keep the first (lowest index) match of each stamp.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_first_q  <= 1'b0;
			hit_second_q <= 1'b0;
		end else if (ctl.clear) begin
			hit_first_q  <= 1'b0;
			hit_second_q <= 1'b0;
		end else begin
			if (match_first) begin
				hit_first_q <= 1'b1;
			end
			if (match_second) begin
				hit_second_q <= 1'b1;
			end
		end
	end

	// Captured slot contents of each hit.
	always_ff @(posedge clk) begin
		if (match_first) begin
			word_first_q <= eff_word;
		end
		if (match_second) begin
			word_second_q <= eff_word;
		end
	end

	// The stamp after the seen one wins over the newest stamp.
	assign found    = hit_first_q || hit_second_q;
	assign hit_word = hit_first_q ? word_first_q : word_second_q;

	`SERL_ASSERT_NEXT(a_hits_hold, !ctl.clear && !ctl.cmp_en, $stable(hit_first_q) && $stable(hit_second_q), "hit flags changed without a compare")
	`SERL_ASSERT_NEXT(a_clear_drops, ctl.clear, !hit_first_q && !hit_second_q, "hit flags survived a clear")
	`SERL_ASSERT_IMPL(a_second_used, hit_second_q, use_second, "newest-stamp hit recorded while not wanted")

endmodule

FILE: rtl/core/sequenced_event_ring_log_core.sv
// Top level of the sequenced event ring log: sequencer, counters and output register.
//
// Ring log of events held in one slot memory with a single read port. A push
// stores the event at the write index, stamps it with the running sequence
// number and goes from acceptance straight to the emit step. So does a fetch
// whose seen number is out of range, or that finds the log empty. Any other
// fetch scans every slot once through the memory read port, checking each
// slot against both the stamp after the seen one and the newest stamp, then
// passes through the flush step to emit. One transaction is in work at a time;
// a new one is accepted while the previous result still waits in the output
// register. Slots not yet written since reset are tracked with a fill count
// and read as their reset contents, so no clearing pass is needed.
`include "sequenced_event_ring_log_core_assert.svh"

module sequenced_event_ring_log_core #(
	parameter int LOG_DEPTH     = serl_pkg::DEF_LOG_DEPTH,
	parameter int COUNTER_LIMIT = serl_pkg::DEF_COUNTER_LIMIT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              req_type,
	input  logic [serl_pkg::ID_W-1:0]         event_id,
	input  logic [serl_pkg::AUX_W-1:0]        aux_first,
	input  logic [serl_pkg::AUX_W-1:0]        aux_second,
	input  logic [serl_pkg::SEEN_W-1:0]       after_counter,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic [serl_pkg::ID_W-1:0]         out_event_id,
	output logic [serl_pkg::AUX_W-1:0]        out_aux_first,
	output logic [serl_pkg::AUX_W-1:0]        out_aux_second,
	output logic [$clog2(COUNTER_LIMIT)-1:0]  out_counter,
	output logic [$clog2(COUNTER_LIMIT)-1:0]  last_counter
);
	import serl_pkg::*;

	localparam int CW     = $clog2(COUNTER_LIMIT);
	localparam int AW     = $clog2(LOG_DEPTH);
	localparam int FW     = $clog2(LOG_DEPTH + 1);
	localparam int WORD_W = ID_W + 2 * AUX_W + CW;
	localparam logic [CW-1:0] STAMP_MAX = CW'(COUNTER_LIMIT - 1);
	localparam logic [AW-1:0] IDX_MAX   = AW'(LOG_DEPTH - 1);
	localparam logic [FW-1:0] FILL_FULL = FW'(LOG_DEPTH);
	localparam logic [SEEN_W:0] LIMIT_X = (SEEN_W + 1)'(COUNTER_LIMIT);

	serl_state_t    state_q;
	serl_state_t    state_d;
	serl_scan_ctl_t scan_ctl;

	logic              in_acc;
	logic              is_fetch;
	logic              seen_bad;
	logic [CW-1:0]     seen_c;
	logic [CW-1:0]     newest;
	logic              wr_en;
	logic              rd_en;
	logic              out_load;
	logic [WORD_W-1:0] wr_word;
	logic [WORD_W-1:0] rd_word;
	logic [WORD_W-1:0] hit_word;
	logic              found;

	logic [AW-1:0]     wr_idx_q;
	logic [FW-1:0]     fill_q;
	logic [CW-1:0]     next_stamp_q;
	logic [AW-1:0]     scan_idx_q;
	logic [AW-1:0]     idx_s1;
	logic              rd_vld_s1;
	logic [CW-1:0]     tgt_first_q;
	logic [CW-1:0]     tgt_second_q;
	logic              use_second_q;
	logic              res_scan_q;
	logic [1:0]        res_status_q;
	logic              out_valid_q;

	// Request decode.
	assign in_acc   = in_valid && in_ready;
	assign is_fetch = (serl_req_t'(req_type) == REQ_FETCH);
	assign seen_bad = ({1'b0, after_counter} >= LIMIT_X);
	assign seen_c   = CW'(after_counter);
	assign newest   = (next_stamp_q == '0) ? STAMP_MAX : next_stamp_q - 1'b1;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SERL_IDLE: begin
				if (in_valid) begin
					if (is_fetch && !seen_bad && (next_stamp_q != CW'(1))) begin
						state_d = SERL_SCAN;
					end else begin
						state_d = SERL_EMIT;
					end
				end
			end
			SERL_SCAN: begin
				if (scan_idx_q == IDX_MAX) begin
					state_d = SERL_FLUSH;
				end
			end
			SERL_FLUSH: begin
				state_d = SERL_EMIT;
			end
			SERL_EMIT: begin
				if (!out_valid_q || out_ready) begin
					state_d = SERL_IDLE;
				end
			end
			default: begin
				state_d = SERL_IDLE;
			end
		endcase
	end

	// State-driven outputs.
	always_comb begin
		in_ready        = 1'b0;
		rd_en           = 1'b0;
		out_load        = 1'b0;
		scan_ctl.clear  = 1'b0;
		unique case (state_q)
			SERL_IDLE: begin
				in_ready       = 1'b1;
				scan_ctl.clear = in_valid;
			end
			SERL_SCAN: begin
				rd_en = 1'b1;
			end
			SERL_FLUSH: begin
			end
			SERL_EMIT: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
		scan_ctl.cmp_en = rd_vld_s1;
		scan_ctl.live   = (FW'(idx_s1) < fill_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SERL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Push path: the memory is written only from idle, so a scan never overlaps it.
	assign wr_en   = in_acc && !is_fetch;
	assign wr_word = {event_id, aux_first, aux_second, next_stamp_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q     <= '0;
			fill_q       <= '0;
			next_stamp_q <= CW'(1);
		end else if (wr_en) begin
			wr_idx_q     <= (wr_idx_q == IDX_MAX) ? '0 : wr_idx_q + 1'b1;
			next_stamp_q <= (next_stamp_q == STAMP_MAX) ? '0 : next_stamp_q + 1'b1;
			if (fill_q != FILL_FULL) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Scan address counter and read-data stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (in_acc) begin
				scan_idx_q <= '0;
			end else if (rd_en) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx_q;
	end

	// Wanted stamps and the status of transactions that need no scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_scan_q   <= 1'b0;
			res_status_q <= STATUS_OK;
		end else if (in_acc) begin
			res_scan_q <= 1'b0;
			if (!is_fetch) begin
				res_status_q <= STATUS_OK;
			end else if (seen_bad) begin
				res_status_q <= STATUS_RANGE;
			end else if (next_stamp_q == CW'(1)) begin
				res_status_q <= STATUS_EMPTY;
			end else begin
				res_scan_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			tgt_first_q  <= (seen_c == STAMP_MAX) ? '0 : seen_c + 1'b1;
			tgt_second_q <= newest;
			use_second_q <= (newest != seen_c);
		end
	end

	serl_mem #(
		.DEPTH (LOG_DEPTH),
		.WIDTH (WORD_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_idx_q),
		.wr_data (wr_word),
		.rd_en   (rd_en),
		.rd_addr (scan_idx_q),
		.rd_data (rd_word)
	);

	serl_scan #(
		.COUNTER_LIMIT (COUNTER_LIMIT)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.rd_word    (rd_word),
		.tgt_first  (tgt_first_q),
		.tgt_second (tgt_second_q),
		.use_second (use_second_q),
		.found      (found),
		.hit_word   (hit_word)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload; failed fetches and pushes carry zero slot fields.
	always_ff @(posedge clk) begin
		if (out_load) begin
			last_counter <= newest;
			if (res_scan_q && found) begin
				status         <= STATUS_OK;
				out_event_id   <= hit_word[WORD_W-1 -: ID_W];
				out_aux_first  <= hit_word[2*AUX_W+CW-1 -: AUX_W];
				out_aux_second <= hit_word[AUX_W+CW-1 -: AUX_W];
				out_counter    <= hit_word[CW-1:0];
			end else begin
				status         <= res_scan_q ? STATUS_NOTFOUND : res_status_q;
				out_event_id   <= '0;
				out_aux_first  <= '0;
				out_aux_second <= '0;
				out_counter    <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`SERL_ASSERT_IMPL(a_no_write_busy, state_q != SERL_IDLE, !wr_en, "slot memory written while a transaction is in work")
	`SERL_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= FILL_FULL, "fill count beyond the log depth")
	`SERL_ASSERT_IMPL(a_rose_from_emit, $rose(out_valid_q), $past(state_q) == SERL_EMIT, "result presented outside the emit step")

endmodule
